// ===== design/btlv_pkg.sv =====
// Shared types and constants for the BER TLV header walker.
package btlv_pkg;

   // Parse phase of the current element
   typedef enum logic [2:0] {
      PH_TAG0  = 3'd0,
      PH_TAGN  = 3'd1,
      PH_LEN0  = 3'd2,
      PH_LENX  = 3'd3,
      PH_CONT  = 3'd4,
      PH_INDEF = 3'd5,
      PH_HALT  = 3'd6
   } phase_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADTAG = 2'd1,
      ST_BADLEN = 2'd2,
      ST_TRUNC  = 2'd3
   } status_type;

   // Register indexes on the configuration port
   localparam logic REG_TARGET_TAG = 1'b0;

   localparam int TAG_W    = 24;
   localparam int CLEN_W   = 16;
   localparam int ESIZE_W  = 17;
   localparam int HDR_W    = 3;
   localparam int RSP_W    = 72;
   localparam int CSR_AW   = 3;

   localparam logic [7:0]  TAG_MULTI_MASK = 8'h1F;
   localparam logic [7:0]  LEN_INDEF      = 8'h80;
   localparam logic [1:0]  TAG_MAX_BYTES  = 2'd3;
   localparam logic [1:0]  LEN_MAX_BYTES  = 2'd2;
   localparam logic [ESIZE_W-1:0] INDEF_LIMIT = 17'd65537;

endpackage

// ===== design/ber_tlv_header_walker_core.sv =====
// Datapath: an accepted item passes through the input register, then the result register;
//   an item that ends no element gives no result.
// Throughput: one byte per cycle, set by the state update between the two registers;
//   a held result stalls the input only when the input register is also full.
// Reset (synchronous, active high) clears the parse state to "expecting first tag byte",
//   empties both registers and sets target_tag to zero.
module ber_tlv_header_walker_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] region_start
   input  logic        req_tlast,   // region_end
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [23:0] tag_raw, [25:24] tag_bytes, [27:26] length_bytes, [43:28] content_length,
   // [44] indefinite, [61:45] element_size, [62] tag_match, [64:63] status, [71:65] zero
   output logic [71:0] rsp_tdata,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // Configuration register
   logic [23:0] target_tag_ff;
   logic        csr_reg_idx;

   // Input register
   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;
   logic        in_end_ff;

   // Parse state
   btlv_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [23:0] tag_acc_ff, tag_acc_in;
   logic [1:0]  tag_count_ff, tag_count_in;
   logic [1:0]  len_left_ff, len_left_in;
   logic [15:0] len_acc_ff, len_acc_in;
   logic [16:0] cont_count_ff, cont_count_in;
   logic        zero_seen_ff, zero_seen_in;
   logic        indef_ff, indef_in;
   logic [2:0]  hdr_count_ff, hdr_count_in;

   // Result formation
   logic                   emit;
   btlv_pkg::status_type   status;
   logic [15:0]            clen;
   logic [2:0]             len_bytes_full;
   logic [16:0]            elem_size;
   logic                   match;
   logic [71:0]            rsp_data_in;

   // Result register
   logic        rsp_valid_ff;
   logic [71:0] rsp_data_ff;

   logic        out_free;
   logic        proc;

   // Handshakes
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || proc;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Configuration port
   assign csr_reg_idx = csr_paddr[2];
   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_reg_idx == btlv_pkg::REG_TARGET_TAG) ?
                        {8'd0, target_tag_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_tag_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_reg_idx == btlv_pkg::REG_TARGET_TAG) begin
         target_tag_ff <= csr_pwdata[23:0];
      end
   end

   // Input register: load on accept, drop once processed
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_start_ff <= req_tuser[0];
         in_end_ff   <= req_tlast;
      end
   end

   // Next parse state and result for the held byte
   always_comb begin
      phase_in      = phase_ff;
      tag_acc_in    = tag_acc_ff;
      tag_count_in  = tag_count_ff;
      len_left_in   = len_left_ff;
      len_acc_in    = len_acc_ff;
      cont_count_in = cont_count_ff;
      zero_seen_in  = zero_seen_ff;
      indef_in      = indef_ff;
      hdr_count_in  = hdr_count_ff;
      emit          = 1'b0;
      status        = btlv_pkg::ST_OK;
      clen          = '0;
      cur_phase     = phase_ff;

      // Restart on a region start
      if (in_start_ff) begin
         cur_phase     = btlv_pkg::PH_TAG0;
         tag_acc_in    = '0;
         tag_count_in  = '0;
         len_left_in   = '0;
         len_acc_in    = '0;
         cont_count_in = '0;
         zero_seen_in  = 1'b0;
         indef_in      = 1'b0;
         hdr_count_in  = '0;
      end

      case (cur_phase)
         btlv_pkg::PH_TAG0: begin
            tag_acc_in    = {16'd0, in_byte_ff};
            tag_count_in  = 2'd1;
            hdr_count_in  = 3'd1;
            len_left_in   = '0;
            len_acc_in    = '0;
            cont_count_in = '0;
            zero_seen_in  = 1'b0;
            indef_in      = 1'b0;
            if ((in_byte_ff & btlv_pkg::TAG_MULTI_MASK) == btlv_pkg::TAG_MULTI_MASK) begin
               phase_in = btlv_pkg::PH_TAGN;
            end else begin
               phase_in = btlv_pkg::PH_LEN0;
            end
         end
         btlv_pkg::PH_TAGN: begin
            tag_acc_in   = {tag_acc_ff[15:0], in_byte_ff};
            tag_count_in = tag_count_ff + 2'd1;
            hdr_count_in = hdr_count_ff + 3'd1;
            if (!in_byte_ff[7]) begin
               phase_in = btlv_pkg::PH_LEN0;
            end else if (tag_count_in == btlv_pkg::TAG_MAX_BYTES) begin
               emit     = 1'b1;
               status   = btlv_pkg::ST_BADTAG;
               phase_in = btlv_pkg::PH_HALT;
            end
         end
         btlv_pkg::PH_LEN0: begin
            hdr_count_in = hdr_count_ff + 3'd1;
            if (in_byte_ff == btlv_pkg::LEN_INDEF) begin
               indef_in      = 1'b1;
               zero_seen_in  = 1'b0;
               cont_count_in = '0;
               phase_in      = btlv_pkg::PH_INDEF;
            end else if (in_byte_ff[7]) begin
               if (in_byte_ff[6:0] > {5'd0, btlv_pkg::LEN_MAX_BYTES}) begin
                  emit     = 1'b1;
                  status   = btlv_pkg::ST_BADLEN;
                  phase_in = btlv_pkg::PH_HALT;
               end else begin
                  len_left_in = in_byte_ff[1:0];
                  len_acc_in  = '0;
                  phase_in    = btlv_pkg::PH_LENX;
               end
            end else begin
               len_acc_in    = {8'd0, in_byte_ff};
               cont_count_in = '0;
               if (in_byte_ff == 8'd0) begin
                  emit     = 1'b1;
                  phase_in = btlv_pkg::PH_TAG0;
               end else begin
                  phase_in = btlv_pkg::PH_CONT;
               end
            end
         end
         btlv_pkg::PH_LENX: begin
            hdr_count_in = hdr_count_ff + 3'd1;
            len_acc_in   = {len_acc_ff[7:0], in_byte_ff};
            if (len_left_ff != 2'd0) begin
               len_left_in = len_left_ff - 2'd1;
            end
            if (len_left_in == 2'd0) begin
               cont_count_in = '0;
               if (len_acc_in == 16'd0) begin
                  emit     = 1'b1;
                  phase_in = btlv_pkg::PH_TAG0;
               end else begin
                  phase_in = btlv_pkg::PH_CONT;
               end
            end
         end
         btlv_pkg::PH_CONT: begin
            cont_count_in = cont_count_ff + 17'd1;
            if (cont_count_in >= {1'b0, len_acc_ff}) begin
               emit     = 1'b1;
               clen     = len_acc_ff;
               phase_in = btlv_pkg::PH_TAG0;
            end
         end
         btlv_pkg::PH_INDEF: begin
            cont_count_in = cont_count_ff + 17'd1;
            if (in_byte_ff == 8'd0 && zero_seen_ff) begin
               emit     = 1'b1;
               clen     = cont_count_in[15:0] - 16'd2;
               phase_in = btlv_pkg::PH_TAG0;
            end else if (cont_count_in >= btlv_pkg::INDEF_LIMIT) begin
               emit     = 1'b1;
               status   = btlv_pkg::ST_BADLEN;
               phase_in = btlv_pkg::PH_HALT;
            end else begin
               zero_seen_in = (in_byte_ff == 8'd0);
            end
         end
         default: begin
            phase_in = btlv_pkg::PH_HALT;
         end
      endcase

      // Region end: report truncation if inside an element, then halt
      if (in_end_ff) begin
         if (!emit && phase_in != btlv_pkg::PH_TAG0 && phase_in != btlv_pkg::PH_HALT) begin
            emit   = 1'b1;
            status = btlv_pkg::ST_TRUNC;
         end
         phase_in = btlv_pkg::PH_HALT;
      end

      if (status != btlv_pkg::ST_OK) begin
         clen = '0;
      end
   end

   // Pack the result fields
   assign len_bytes_full = hdr_count_in - {1'b0, tag_count_in};
   assign elem_size      = {14'd0, hdr_count_in} + cont_count_in;
   assign match          = (status == btlv_pkg::ST_OK) && (tag_acc_in == target_tag_ff);
   assign rsp_data_in    = {7'd0, status, match, elem_size, indef_in, clen,
                            len_bytes_full[1:0], tag_count_in, tag_acc_in};

   // Parse state register: advance once per processed byte
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= btlv_pkg::PH_TAG0;
         tag_acc_ff    <= '0;
         tag_count_ff  <= '0;
         len_left_ff   <= '0;
         len_acc_ff    <= '0;
         cont_count_ff <= '0;
         zero_seen_ff  <= 1'b0;
         indef_ff      <= 1'b0;
         hdr_count_ff  <= '0;
      end else if (proc) begin
         phase_ff      <= phase_in;
         tag_acc_ff    <= tag_acc_in;
         tag_count_ff  <= tag_count_in;
         len_left_ff   <= len_left_in;
         len_acc_ff    <= len_acc_in;
         cont_count_ff <= cont_count_in;
         zero_seen_ff  <= zero_seen_in;
         indef_ff      <= indef_in;
         hdr_count_ff  <= hdr_count_in;
      end
   end

   // Result register: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= proc && emit;
      end
      if (proc && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== design/btlv_checker.sv =====
// Port-level checks for the BER TLV header walker, bound to the top level.
module btlv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // No result straight after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // A tag match only comes with an ok status
   a_match_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[62] |-> rsp_tdata[64:63] == btlv_pkg::ST_OK)
      else $error("tag match on a failed element");

   // Indefinite form always has exactly one length byte
   a_indef_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[44] |-> rsp_tdata[27:26] == 2'd1)
      else $error("indefinite element with wrong length byte count");

   // Element size covers at least the header
   a_size_hdr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[61:45] >= ({15'd0, rsp_tdata[25:24]}
                                         + {15'd0, rsp_tdata[27:26]}))
      else $error("element size below header size");

endmodule

bind ber_tlv_header_walker_core btlv_checker u_btlv_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the BER TLV header walker: directed table, then random regions.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLK_PERIOD     = 10;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int SEGMENT_ITEMS  = 185;

   // One result item, laid out exactly as rsp_tdata[64:0]
   typedef struct packed {
      btlv_pkg::status_type status;
      logic        tag_match;
      logic [16:0] element_size;
      logic        indefinite;
      logic [15:0] content_length;
      logic [1:0]  length_bytes;
      logic [1:0]  tag_bytes;
      logic [23:0] tag_raw;
   } tlv_result_type;

   // One row of the directed table; pinned rows carry a hand-written result
   typedef struct {
      logic [7:0]     data;
      bit             start;
      bit             last;
      bit             pinned;
      tlv_result_type result;
   } stim_row_type;

   localparam tlv_result_type NO_RESULT = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic [0:0]  req_tuser = 1'b0;    // [0] region_start
   logic        req_tlast = 1'b0;    // region_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [23:0] tag_raw, [25:24] tag_bytes, [27:26] length_bytes, [43:28] content_length,
   // [44] indefinite, [61:45] element_size, [62] tag_match, [64:63] status, [71:65] zero
   logic [71:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = 3'd0;
   logic [31:0] csr_pwdata = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   // Walker state mirrored by the predictor
   btlv_pkg::phase_type wk_phase = btlv_pkg::PH_TAG0;
   logic [23:0] wk_tag      = '0;
   logic [1:0]  wk_tag_cnt  = '0;
   logic [1:0]  wk_len_left = '0;
   logic [15:0] wk_len      = '0;
   logic [16:0] wk_count    = '0;
   logic        wk_zero     = 1'b0;
   logic        wk_indef    = 1'b0;
   logic [2:0]  wk_hdr      = '0;
   logic [23:0] target_cfg  = '0;

   tlv_result_type expected_results[$];
   logic [7:0]  region_bytes[$];
   int          fail_count = 0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   int          send_idle_pct = 35;
   int          recv_idle_pct = 60;

   ber_tlv_header_walker_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic tlv_result_type fixed_result(logic [23:0] tag, logic [1:0] tb,
                                                   logic [1:0] lb, logic [16:0] size,
                                                   logic match, btlv_pkg::status_type st);
      tlv_result_type r;
      r = '0;
      r.tag_raw      = tag;
      r.tag_bytes    = tb;
      r.length_bytes = lb;
      r.element_size = size;
      r.tag_match    = match;
      r.status       = st;
      return r;
   endfunction

   // Directed walk: short form, 3-byte tag, long forms, indefinite, every error
   stim_row_type directed_rows[] = '{
      '{8'h02, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b1,
        fixed_result(24'h000002, 2'd1, 2'd1, 17'd2, 1'b1, btlv_pkg::ST_OK)},
      '{8'h1F, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h81, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h7F, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h30, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h82, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h24, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h05, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, 1'b0, NO_RESULT},
      '{8'h1F, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h81, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h82, 1'b0, 1'b0, 1'b1,
        fixed_result(24'h1F8182, 2'd3, 2'd0, 17'd3, 1'b0, btlv_pkg::ST_BADTAG)},
      '{8'h55, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h04, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h83, 1'b0, 1'b0, 1'b1,
        fixed_result(24'h000004, 2'd1, 2'd1, 17'd2, 1'b0, btlv_pkg::ST_BADLEN)},
      '{8'h30, 1'b1, 1'b0, 1'b0, NO_RESULT},
      '{8'h05, 1'b0, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b1, 1'b1,
        fixed_result(24'h000030, 2'd1, 2'd1, 17'd3, 1'b0, btlv_pkg::ST_TRUNC)},
      '{8'hFF, 1'b1, 1'b1, 1'b1,
        fixed_result(24'h0000FF, 2'd1, 2'd0, 17'd1, 1'b0, btlv_pkg::ST_TRUNC)}
   };

   function automatic string show_result(tlv_result_type r);
      return $sformatf("tag=%06h tb=%0d lb=%0d clen=%0d ind=%0d size=%0d match=%0d st=%s",
                       r.tag_raw, r.tag_bytes, r.length_bytes, r.content_length,
                       r.indefinite, r.element_size, r.tag_match, r.status.name());
   endfunction

   function automatic void note_failure(string msg);
      fail_count++;
      if (fail_count <= 10)
         $display("%s", msg);
   endfunction

   function automatic void clear_element();
      wk_tag      = '0;
      wk_tag_cnt  = '0;
      wk_len_left = '0;
      wk_len      = '0;
      wk_count    = '0;
      wk_zero     = 1'b0;
      wk_indef    = 1'b0;
      wk_hdr      = '0;
   endfunction

   function automatic tlv_result_type element_result(btlv_pkg::status_type st,
                                                     logic [15:0] clen);
      tlv_result_type r;
      r.tag_raw        = wk_tag;
      r.tag_bytes      = wk_tag_cnt;
      r.length_bytes   = (wk_hdr >= {1'b0, wk_tag_cnt}) ? 2'(wk_hdr - {1'b0, wk_tag_cnt}) : 2'd0;
      r.content_length = (st == btlv_pkg::ST_OK) ? clen : 16'd0;
      r.indefinite     = wk_indef;
      r.element_size   = 17'(wk_hdr) + wk_count;
      r.tag_match      = (st == btlv_pkg::ST_OK) && (wk_tag == target_cfg);
      r.status         = st;
      return r;
   endfunction

   // Advance the walker by one byte; return 1 when the byte closes an element
   function automatic bit walk_byte(logic [7:0] b, bit s, bit e, output tlv_result_type r);
      bit got;
      got = 1'b0;
      r   = '0;
      if (s) begin
         wk_phase = btlv_pkg::PH_TAG0;
         clear_element();
      end
      case (wk_phase)
         btlv_pkg::PH_TAG0: begin
            clear_element();
            wk_tag     = {16'h0000, b};
            wk_tag_cnt = 2'd1;
            wk_hdr     = 3'd1;
            wk_phase   = ((b & btlv_pkg::TAG_MULTI_MASK) == btlv_pkg::TAG_MULTI_MASK) ?
                         btlv_pkg::PH_TAGN : btlv_pkg::PH_LEN0;
         end
         btlv_pkg::PH_TAGN: begin
            wk_tag     = {wk_tag[15:0], b};
            wk_tag_cnt = wk_tag_cnt + 2'd1;
            wk_hdr     = wk_hdr + 3'd1;
            if (!b[7]) begin
               wk_phase = btlv_pkg::PH_LEN0;
            end else if (wk_tag_cnt >= btlv_pkg::TAG_MAX_BYTES) begin
               r        = element_result(btlv_pkg::ST_BADTAG, 16'd0);
               got      = 1'b1;
               wk_phase = btlv_pkg::PH_HALT;
            end
         end
         btlv_pkg::PH_LEN0: begin
            wk_hdr = wk_hdr + 3'd1;
            if (b == btlv_pkg::LEN_INDEF) begin
               wk_indef = 1'b1;
               wk_zero  = 1'b0;
               wk_count = '0;
               wk_phase = btlv_pkg::PH_INDEF;
            end else if (b[7]) begin
               if (b[6:0] > 7'(btlv_pkg::LEN_MAX_BYTES)) begin
                  r        = element_result(btlv_pkg::ST_BADLEN, 16'd0);
                  got      = 1'b1;
                  wk_phase = btlv_pkg::PH_HALT;
               end else begin
                  wk_len_left = b[1:0];
                  wk_len      = '0;
                  wk_phase    = btlv_pkg::PH_LENX;
               end
            end else begin
               wk_len   = {8'h00, b};
               wk_count = '0;
               if (b == 8'h00) begin
                  r        = element_result(btlv_pkg::ST_OK, 16'd0);
                  got      = 1'b1;
                  wk_phase = btlv_pkg::PH_TAG0;
               end else begin
                  wk_phase = btlv_pkg::PH_CONT;
               end
            end
         end
         btlv_pkg::PH_LENX: begin
            wk_hdr = wk_hdr + 3'd1;
            wk_len = {wk_len[7:0], b};
            if (wk_len_left != 2'd0)
               wk_len_left = wk_len_left - 2'd1;
            if (wk_len_left == 2'd0) begin
               wk_count = '0;
               if (wk_len == 16'd0) begin
                  r        = element_result(btlv_pkg::ST_OK, 16'd0);
                  got      = 1'b1;
                  wk_phase = btlv_pkg::PH_TAG0;
               end else begin
                  wk_phase = btlv_pkg::PH_CONT;
               end
            end
         end
         btlv_pkg::PH_CONT: begin
            wk_count = wk_count + 17'd1;
            if (wk_count >= {1'b0, wk_len}) begin
               r        = element_result(btlv_pkg::ST_OK, wk_len);
               got      = 1'b1;
               wk_phase = btlv_pkg::PH_TAG0;
            end
         end
         btlv_pkg::PH_INDEF: begin
            wk_count = wk_count + 17'd1;
            if (b == 8'h00 && wk_zero) begin
               r        = element_result(btlv_pkg::ST_OK, 16'(wk_count - 17'd2));
               got      = 1'b1;
               wk_phase = btlv_pkg::PH_TAG0;
            end else if (wk_count >= btlv_pkg::INDEF_LIMIT) begin
               r        = element_result(btlv_pkg::ST_BADLEN, 16'd0);
               got      = 1'b1;
               wk_phase = btlv_pkg::PH_HALT;
            end else begin
               wk_zero = (b == 8'h00);
            end
         end
         default: wk_phase = btlv_pkg::PH_HALT;
      endcase
      // Region end: flag an unfinished element, then hold until the next start
      if (e) begin
         if (!got && wk_phase != btlv_pkg::PH_TAG0 && wk_phase != btlv_pkg::PH_HALT) begin
            r   = element_result(btlv_pkg::ST_TRUNC, 16'd0);
            got = 1'b1;
         end
         wk_phase = btlv_pkg::PH_HALT;
      end
      return got;
   endfunction

   // Present one item, wait for its acceptance and queue what it should give
   task automatic send_byte(logic [7:0] b, bit s, bit e, bit pinned,
                            tlv_result_type pinned_r);
      tlv_result_type r;
      bit             got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tuser  <= s;
      req_tlast  <= e;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      got = walk_byte(b, s, e, r);
      if (pinned)
         expected_results.push_back(pinned_r);
      else if (got)
         expected_results.push_back(r);
   endtask

   task automatic send_plain(logic [7:0] b, bit s, bit e);
      send_byte(b, s, e, 1'b0, NO_RESULT);
   endtask

   // Drain every expected result, then let the pipeline empty out
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write target_tag, then read it back
   task automatic csr_write_tag(logic [23:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {btlv_pkg::REG_TARGET_TAG, 2'b00};
      csr_pwdata  <= {8'h00, v};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[23:0] !== v)
         note_failure($sformatf("target_tag readback: expected %06h, got %06h", v,
                                csr_prdata[23:0]));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      target_cfg = v;
   endtask

   // Append one well-formed element with random tag, length form and content
   function automatic void add_element();
      int          tk;
      int          lk;
      int          clen;
      logic [7:0]  b;
      logic [23:0] t;
      tk = $urandom_range(0, 9);
      if (tk < 3) begin
         t = target_cfg;
         if (t[23:16] != 8'h00) region_bytes.push_back(t[23:16]);
         if (t[23:8] != 16'h0000) region_bytes.push_back(t[15:8]);
         region_bytes.push_back(t[7:0]);
      end else if (tk < 7) begin
         b = 8'($urandom);
         if ((b & btlv_pkg::TAG_MULTI_MASK) == btlv_pkg::TAG_MULTI_MASK) b[0] = 1'b0;
         region_bytes.push_back(b);
      end else if (tk < 9) begin
         region_bytes.push_back({3'($urandom), 5'h1F});
         region_bytes.push_back({1'b0, 7'($urandom)});
      end else begin
         region_bytes.push_back({3'($urandom), 5'h1F});
         region_bytes.push_back({1'b1, 7'($urandom)});
         region_bytes.push_back({1'b0, 7'($urandom)});
      end
      lk = $urandom_range(0, 9);
      if (lk < 5) begin
         clen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 8);
         region_bytes.push_back(8'(clen));
      end else if (lk < 7) begin
         clen = $urandom_range(0, 20);
         region_bytes.push_back(8'h81);
         region_bytes.push_back(8'(clen));
      end else if (lk == 7) begin
         clen = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 12);
         region_bytes.push_back(8'h82);
         region_bytes.push_back(8'(clen >> 8));
         region_bytes.push_back(8'(clen));
      end else begin
         // Indefinite: single zeros inside, never a pair, last content byte non-zero
         region_bytes.push_back(btlv_pkg::LEN_INDEF);
         clen = $urandom_range(0, 8);
         for (int i = 0; i < clen; i++) begin
            b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            if ((i > 0 && region_bytes[$] == 8'h00) || i == clen - 1)
               b = 8'($urandom_range(1, 255));
            region_bytes.push_back(b);
         end
         region_bytes.push_back(8'h00);
         region_bytes.push_back(8'h00);
         return;
      end
      repeat (clen) region_bytes.push_back(8'($urandom));
   endfunction

   // Append a bad tag or an unsupported length form, with a few bytes that get ignored
   function automatic void add_broken_element();
      logic [7:0] b;
      if ($urandom_range(0, 1) == 0) begin
         region_bytes.push_back({3'($urandom), 5'h1F});
         region_bytes.push_back({1'b1, 7'($urandom)});
         region_bytes.push_back({1'b1, 7'($urandom)});
      end else begin
         b = 8'($urandom);
         if ((b & btlv_pkg::TAG_MULTI_MASK) == btlv_pkg::TAG_MULTI_MASK) b[0] = 1'b0;
         region_bytes.push_back(b);
         region_bytes.push_back(8'($urandom_range(8'h83, 8'hFF)));
      end
      repeat ($urandom_range(0, 2)) region_bytes.push_back(8'($urandom));
   endfunction

   // Send one region: mostly well-formed siblings, sometimes cut, corrupted or pure noise
   task automatic send_region();
      int n_elem;
      int cut;
      bit with_end;
      region_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 12))
            send_plain(8'($urandom), $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
         return;
      end
      n_elem = $urandom_range(1, 4);
      for (int i = 0; i < n_elem; i++) begin
         if ($urandom_range(0, 11) == 0) begin
            add_broken_element();
            break;
         end
         add_element();
      end
      cut = region_bytes.size();
      if ($urandom_range(0, 6) == 0)
         cut = $urandom_range(1, region_bytes.size());
      if ($urandom_range(0, 9) == 0)
         region_bytes[$urandom_range(0, cut - 1)] = 8'($urandom);
      with_end = ($urandom_range(0, 4) != 0);
      for (int i = 0; i < cut; i++)
         send_plain(region_bytes[i], i == 0, with_end && i == cut - 1);
   endtask

   // Receiver back-pressure
   always @(posedge clock)
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin : rsp_check
      tlv_result_type got;
      tlv_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[64:0];
         if (expected_results.size() == 0) begin
            note_failure($sformatf("unexpected result: %s", show_result(got)));
         end else begin
            want = expected_results.pop_front();
            if (got !== want)
               note_failure($sformatf("mismatch: expected %s, got %s",
                                      show_result(want), show_result(got)));
         end
      end
   end

   // Watchdog: end the run if no item moves on either stream for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
         end
      end
   end

   initial begin : main
      logic [23:0] segment_tags[6];
      int          goal;
      segment_tags = '{24'h000000, 24'hFFFFFF, 24'h000030, 24'h005F21, 24'h1F8101,
                       {3'($urandom), 5'h1F, 1'b1, 7'($urandom), 1'b0, 7'($urandom)}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      csr_write_tag(24'h000002);
      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].start, directed_rows[i].last,
                   directed_rows[i].pinned, directed_rows[i].result);

      // Random regions over three idling regimes and six target settings
      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 35 : (seg < 4) ? 60 : 0;
         recv_idle_pct = (seg < 2) ? 60 : (seg < 4) ? 35 : 0;
         settle();
         csr_write_tag(segment_tags[seg]);
         goal = items_sent + SEGMENT_ITEMS;
         while (items_sent < goal) send_region();
      end

      settle();
      if (fail_count == 0 && expected_results.size() == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
